FILE: rtl/core/light_english_suffix_stripper_top_assert.svh
// Assertion macros shared by the suffix stripper RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef LIGHT_ENGLISH_SUFFIX_STRIPPER_TOP_ASSERT_SVH
`define LIGHT_ENGLISH_SUFFIX_STRIPPER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked at every clock edge outside reset.
`define LSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("suffix stripper assertion failed");
// Checked at every clock edge, reset included.
`define LSS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("suffix stripper assertion failed");
`else
`define LSS_ASSERT(label, prop)
`define LSS_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: rtl/core/lss_pkg.sv
package lss_pkg;

  // Longest term that is stemmed; longer terms are flagged.
  localparam int MAX_TERM_LEN = 255;
  // The letter counter saturates at MAX_TERM_LEN + 1.
  localparam int CNT_W = $clog2(MAX_TERM_LEN + 2);

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CHAR_D = 8'h64;
  localparam logic [7:0] CHAR_E = 8'h65;
  localparam logic [7:0] CHAR_G = 8'h67;
  localparam logic [7:0] CHAR_I = 8'h69;
  localparam logic [7:0] CHAR_L = 8'h6C;
  localparam logic [7:0] CHAR_N = 8'h6E;
  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_Y = 8'h79;

  typedef enum logic [14:0] {
    ST_FIRST  = 15'b000000000000001,
    ST_SECOND = 15'b000000000000010,
    ST_NONE   = 15'b000000000000100,
    ST_E      = 15'b000000000001000,
    ST_EDS    = 15'b000000000010000,
    ST_S      = 15'b000000000100000,
    ST_I      = 15'b000000001000000,
    ST_IE     = 15'b000000010000000,
    ST_IESD   = 15'b000000100000000,
    ST_IN     = 15'b000001000000000,
    ST_ING    = 15'b000010000000000,
    ST_INGL   = 15'b000100000000000,
    ST_INGLY  = 15'b001000000000000,
    ST_L      = 15'b010000000000000,
    ST_LY     = 15'b100000000000000
  } scan_state_t;

  typedef struct packed {
    logic [7:0] keep_length;
    logic       append_y;
    logic       too_long;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/lss_scan.sv
// Per-term scanner: letter counter, candidate suffix start and the suffix
// state machine. The result is the verdict for a terminator on char_code.
module lss_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      char_code,
  output lss_pkg::result_t result
);

  localparam int CNT_W = lss_pkg::CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(lss_pkg::MAX_TERM_LEN);
  localparam logic [CNT_W-1:0] OVER_CNT = CNT_W'(lss_pkg::MAX_TERM_LEN + 1);

  lss_pkg::scan_state_t scan_state, scan_state_next, letter_state;
  logic [CNT_W-1:0] letter_count, letter_count_next;
  logic [CNT_W-1:0] suffix_start, suffix_start_next;
  logic [7:0] c;
  logic       restart;

  assign c = lss_pkg::fold_case(char_code);

  // Transition for one letter; restart marks a new candidate at this letter.
  always_comb begin
    letter_state = lss_pkg::ST_NONE;
    restart = 1'b0;
    case (scan_state)
      lss_pkg::ST_FIRST:  letter_state = lss_pkg::ST_SECOND;
      lss_pkg::ST_SECOND: letter_state = lss_pkg::ST_NONE;
      default: begin
        if (scan_state == lss_pkg::ST_L && c == lss_pkg::CHAR_Y) begin
          letter_state = lss_pkg::ST_LY;
        end else if (scan_state == lss_pkg::ST_I && c == lss_pkg::CHAR_E) begin
          letter_state = lss_pkg::ST_IE;
        end else if (scan_state == lss_pkg::ST_I && c == lss_pkg::CHAR_N) begin
          letter_state = lss_pkg::ST_IN;
        end else if (scan_state == lss_pkg::ST_IE &&
                     (c == lss_pkg::CHAR_D || c == lss_pkg::CHAR_S)) begin
          letter_state = lss_pkg::ST_IESD;
        end else if (scan_state == lss_pkg::ST_IN && c == lss_pkg::CHAR_G) begin
          letter_state = lss_pkg::ST_ING;
        end else if (scan_state == lss_pkg::ST_ING && c == lss_pkg::CHAR_L) begin
          letter_state = lss_pkg::ST_INGL;
        end else if (scan_state == lss_pkg::ST_INGL && c == lss_pkg::CHAR_Y) begin
          letter_state = lss_pkg::ST_INGLY;
        end else if (scan_state == lss_pkg::ST_E &&
                     (c == lss_pkg::CHAR_D || c == lss_pkg::CHAR_S)) begin
          letter_state = lss_pkg::ST_EDS;
        end else if (c == lss_pkg::CHAR_E) begin
          letter_state = lss_pkg::ST_E;
          restart = 1'b1;
        end else if (c == lss_pkg::CHAR_I) begin
          letter_state = lss_pkg::ST_I;
          restart = 1'b1;
        end else if (c == lss_pkg::CHAR_L) begin
          letter_state = lss_pkg::ST_L;
          restart = 1'b1;
        end else if (c == lss_pkg::CHAR_S) begin
          letter_state = lss_pkg::ST_S;
          restart = 1'b1;
        end
      end
    endcase
  end

  // Verdict for the term so far.
  always_comb begin
    result.keep_length = 8'(letter_count);
    result.append_y = 1'b0;
    result.too_long = 1'b0;
    if (letter_count > MAX_CNT) begin
      result.keep_length = 8'h00;
      result.too_long = 1'b1;
    end else begin
      case (scan_state)
        lss_pkg::ST_E, lss_pkg::ST_EDS, lss_pkg::ST_S, lss_pkg::ST_ING,
        lss_pkg::ST_INGLY, lss_pkg::ST_LY: begin
          result.keep_length = 8'(suffix_start);
        end
        lss_pkg::ST_IESD: begin
          result.keep_length = 8'(suffix_start);
          result.append_y = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    scan_state_next = scan_state;
    letter_count_next = letter_count;
    suffix_start_next = suffix_start;
    if (char_code == lss_pkg::CHAR_NUL) begin
      scan_state_next = lss_pkg::ST_FIRST;
      letter_count_next = '0;
      suffix_start_next = '0;
    end else if (letter_count < MAX_CNT) begin
      scan_state_next = letter_state;
      letter_count_next = letter_count + 1'b1;
      if (restart) begin
        suffix_start_next = letter_count;
      end
    end else begin
      letter_count_next = OVER_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= lss_pkg::ST_FIRST;
      letter_count <= '0;
      suffix_start <= '0;
    end else if (step) begin
      scan_state <= scan_state_next;
      letter_count <= letter_count_next;
      suffix_start <= suffix_start_next;
    end
  end

endmodule

FILE: rtl/core/light_english_suffix_stripper_top.sv
// Light English suffix stripper.
// A term arrives one byte per transaction on the char channel
// (char_valid, char_ready, char_code); the byte 0 ends the term. Every
// other byte is a letter. For each terminator one transaction leaves on
// the result channel (result_valid, result_ready) carrying keep_length,
// the number of leading letters to keep, append_y, set when a y must be
// written after them (-ies and -ied become -y), and too_long, set with
// the other two fields at zero when the term exceeded the maximum length.
// Letters produce no result transaction.
// Throughput is one byte per cycle while char_ready is high: each byte
// takes one pass through the suffix state machine between the input
// register and the state/result registers. result_valid rises when the
// terminator leaves the input register and its verdict is registered.
// When the receiver stalls, letters keep flowing; a second terminator
// waits in the input register, and char_ready drops only while a
// terminator is held there and the result register is full and stalled.
// Reset clears both valid flags and returns the scanner to the start of
// a term.
module light_english_suffix_stripper_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_code,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] keep_length,
  output logic       append_y,
  output logic       too_long
);

  `include "light_english_suffix_stripper_top_assert.svh"

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_is_term;
  logic       s1_fire;
  logic       term_fire;
  lss_pkg::result_t verdict;

  assign s1_is_term = (s1_char == lss_pkg::CHAR_NUL);
  // A letter always moves on; a terminator needs room in the result register.
  assign s1_fire = s1_valid && (!s1_is_term || !result_valid || result_ready);
  assign term_fire = s1_fire && s1_is_term;
  assign char_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      s1_char <= char_code;
    end
  end

  lss_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .char_code (s1_char),
    .result    (verdict)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (term_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_fire) begin
      keep_length <= verdict.keep_length;
      append_y <= verdict.append_y;
      too_long <= verdict.too_long;
    end
  end

  // An overlong term carries no stem.
  `LSS_ASSERT(a_too_long_clean,
    result_valid && too_long |-> keep_length == 8'h00 && !append_y)
  // A terminator that moves on always shows up as a result.
  `LSS_ASSERT(a_term_gives_result, term_fire |=> result_valid)
  // A full, stalled result register holds any terminator back.
  `LSS_ASSERT(a_no_overwrite,
    result_valid && !result_ready && s1_valid && s1_is_term |-> !s1_fire)
  // Nothing is valid right after reset.
  `LSS_ASSERT_ALWAYS(a_reset_clears,
    $past(rst) |-> !result_valid && !s1_valid)

endmodule

FILE: tb/sv/testbench.sv
module testbench;

  // Lowercase letter bounds, derived from the package so the folding rule
  // below stays in step with the block's own character constants.
  localparam logic [7:0] LOWER_A = lss_pkg::CHAR_UPPER_A + lss_pkg::CASE_OFFSET;
  localparam logic [7:0] LOWER_Z = lss_pkg::CHAR_UPPER_Z + lss_pkg::CASE_OFFSET;

  // Number of random input bytes to send, and how many of them, at the very
  // end, go through with no idle cycles on either side.
  localparam int RANDOM_BYTES = 700;
  localparam int STEADY_BYTES = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic [7:0] char_code = lss_pkg::CHAR_NUL;
  logic       result_ready = 1'b0;
  logic       char_ready;
  logic       result_valid;
  logic [7:0] keep_length;
  logic       append_y;
  logic       too_long;

  light_english_suffix_stripper_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_code    (char_code),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .keep_length  (keep_length),
    .append_y     (append_y),
    .too_long     (too_long)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The stemmer's own view of the current term: which suffix candidate it is
  // tracking, how many letters it has seen, and where the candidate starts.
  lss_pkg::scan_state_t stem_scan = lss_pkg::ST_FIRST;
  int unsigned term_letters = 0;
  int unsigned stem_start = 0;

  // Stem results that have been predicted but not yet seen on the result
  // channel, oldest first.
  lss_pkg::result_t pending_stems[$];

  // When this is low, neither the sender nor the receiver inserts idle cycles.
  bit idle_on = 1'b1;

  int mismatches = 0;
  int sent_bytes = 0;
  int sent_terms = 0;
  int seen_y_stems = 0;
  int seen_overlong = 0;

  // Letters that take part in the suffixes; random terms draw on them heavily
  // so that the suffix machine gets deep into its candidate states.
  logic [7:0] hot_letters [8] = '{lss_pkg::CHAR_E, lss_pkg::CHAR_I,
                                  lss_pkg::CHAR_L, lss_pkg::CHAR_S,
                                  lss_pkg::CHAR_D, lss_pkg::CHAR_N,
                                  lss_pkg::CHAR_G, lss_pkg::CHAR_Y};

  // The suffixes that are stripped or rewritten to -y.
  string suffix_forms [9] = '{"e", "es", "s", "ed", "ing", "ly", "ingly", "ies", "ied"};

  // Moves the suffix tracker forward by one folded letter at index pos. The
  // first two letters only advance the state; after that a letter either
  // extends the current candidate or starts a new one, and anything else
  // drops the candidate.
  function automatic lss_pkg::scan_state_t next_scan(lss_pkg::scan_state_t s,
                                                     logic [7:0] c,
                                                     int unsigned pos,
                                                     ref int unsigned start);
    if (s == lss_pkg::ST_FIRST) return lss_pkg::ST_SECOND;
    if (s == lss_pkg::ST_SECOND) return lss_pkg::ST_NONE;
    if (s == lss_pkg::ST_L && c == lss_pkg::CHAR_Y) return lss_pkg::ST_LY;
    if (s == lss_pkg::ST_I && c == lss_pkg::CHAR_E) return lss_pkg::ST_IE;
    if (s == lss_pkg::ST_I && c == lss_pkg::CHAR_N) return lss_pkg::ST_IN;
    if (s == lss_pkg::ST_IE && (c == lss_pkg::CHAR_D || c == lss_pkg::CHAR_S))
      return lss_pkg::ST_IESD;
    if (s == lss_pkg::ST_IN && c == lss_pkg::CHAR_G) return lss_pkg::ST_ING;
    if (s == lss_pkg::ST_ING && c == lss_pkg::CHAR_L) return lss_pkg::ST_INGL;
    if (s == lss_pkg::ST_INGL && c == lss_pkg::CHAR_Y) return lss_pkg::ST_INGLY;
    if (s == lss_pkg::ST_E && (c == lss_pkg::CHAR_D || c == lss_pkg::CHAR_S))
      return lss_pkg::ST_EDS;
    if (c == lss_pkg::CHAR_E || c == lss_pkg::CHAR_I ||
        c == lss_pkg::CHAR_L || c == lss_pkg::CHAR_S) begin
      start = pos;
      case (c)
        lss_pkg::CHAR_E: return lss_pkg::ST_E;
        lss_pkg::CHAR_I: return lss_pkg::ST_I;
        lss_pkg::CHAR_L: return lss_pkg::ST_L;
        default:         return lss_pkg::ST_S;
      endcase
    end
    return lss_pkg::ST_NONE;
  endfunction

  // Applies one accepted byte to the stemmer. A terminator closes the term and
  // queues the stem result that the block must produce for it.
  function automatic void predict_stem_byte(logic [7:0] raw);
    logic [7:0]       folded;
    lss_pkg::result_t stem;
    int unsigned      kept;
    if (raw != lss_pkg::CHAR_NUL) begin
      if (term_letters < lss_pkg::MAX_TERM_LEN) begin
        folded = (raw >= lss_pkg::CHAR_UPPER_A && raw <= lss_pkg::CHAR_UPPER_Z) ?
                 raw + lss_pkg::CASE_OFFSET : raw;
        stem_scan = next_scan(stem_scan, folded, term_letters, stem_start);
        term_letters++;
      end else begin
        term_letters = lss_pkg::MAX_TERM_LEN + 1;
      end
      return;
    end
    stem = '0;
    if (term_letters > lss_pkg::MAX_TERM_LEN) begin
      // An overlong term is flagged and the other fields stay at zero.
      stem.too_long = 1'b1;
    end else begin
      kept = term_letters;
      case (stem_scan)
        lss_pkg::ST_E, lss_pkg::ST_EDS, lss_pkg::ST_S, lss_pkg::ST_ING,
        lss_pkg::ST_INGLY, lss_pkg::ST_LY: kept = stem_start;
        lss_pkg::ST_IESD: begin
          kept = stem_start;
          stem.append_y = 1'b1;
        end
        default: ;
      endcase
      stem.keep_length = kept[7:0];
    end
    pending_stems.push_back(stem);
    stem_scan = lss_pkg::ST_FIRST;
    term_letters = 0;
    stem_start = 0;
  endfunction

  // Sends one byte on the char channel. The task starts and ends just after a
  // rising edge; an optional idle burst comes first, then valid is held with
  // the byte until the transaction completes.
  task automatic send_byte(logic [7:0] c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    predict_stem_byte(c);
    sent_bytes++;
    if (c == lss_pkg::CHAR_NUL) sent_terms++;
  endtask

  // Sends a whole term written as a string, followed by the terminator.
  task automatic send_word(string w);
    for (int i = 0; i < w.len(); i++) send_byte(w[i]);
    send_byte(lss_pkg::CHAR_NUL);
  endtask

  // Lowers valid and waits until every predicted stem has been received.
  task automatic wait_for_drain();
    char_valid <= 1'b0;
    while (pending_stems.size() != 0) @(posedge clk);
  endtask

  // Draws one random letter: mostly suffix letters, then other letters, and
  // now and then any nonzero byte. Letters are sometimes uppercased.
  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    int         k;
    k = $urandom_range(0, 9);
    if (k < 5) c = hot_letters[$urandom_range(0, 7)];
    else if (k < 8) c = LOWER_A + 8'($urandom_range(0, 25));
    else c = 8'($urandom_range(1, 255));
    if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 2) == 0)
      c = c - lss_pkg::CASE_OFFSET;
    return c;
  endfunction

  // Sends one random term. Most terms are a short random stem plus a listed
  // suffix in random case; the rest are noise or a suffix cut short. A rare
  // term runs right around the maximum length.
  task automatic send_random_term();
    string sfx;
    int    stem_len;
    int    cut;
    logic [7:0] c;
    if ($urandom_range(0, 299) == 0)
      stem_len = lss_pkg::MAX_TERM_LEN - 4 + $urandom_range(0, 8);
    else stem_len = $urandom_range(0, 7);
    for (int i = 0; i < stem_len; i++) send_byte(pick_letter());
    if ($urandom_range(0, 9) < 8) begin
      sfx = suffix_forms[$urandom_range(0, 8)];
      cut = sfx.len();
      // Now and then the suffix is broken off early.
      if ($urandom_range(0, 5) == 0) cut = $urandom_range(0, sfx.len());
      for (int i = 0; i < cut; i++) begin
        c = sfx[i];
        if ($urandom_range(0, 2) == 0) c = c - lss_pkg::CASE_OFFSET;
        send_byte(c);
      end
    end else begin
      repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(1, 255)));
    end
    send_byte(lss_pkg::CHAR_NUL);
  endtask

  // Empty and one- or two-letter terms are kept whole, including the extreme
  // byte values, and a two-letter suffix is never inspected.
  task automatic test_short_terms();
    send_byte(lss_pkg::CHAR_NUL);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(lss_pkg::CHAR_NUL);
    send_word("Q");
    send_word("es");
  endtask

  // Every listed suffix once, each behind the shortest stem and in mixed case.
  task automatic test_suffix_forms();
    send_word("abE");
    send_word("abes");
    send_word("abS");
    send_word("abed");
    send_word("abING");
    send_word("abLy");
    send_word("abingly");
    send_word("abies");
    send_word("abIED");
  endtask

  // Terms at and just above the maximum length. The term of exactly the
  // maximum length is still stemmed; the longer one is flagged.
  task automatic test_overlong_terms();
    int lengths [2] = '{lss_pkg::MAX_TERM_LEN, lss_pkg::MAX_TERM_LEN + 1};
    foreach (lengths[n]) begin
      for (int i = 0; i < lengths[n] - 3; i++) send_byte(pick_letter());
      send_word("ing");
    end
  endtask

  // The bulk of the random terms, with idling on both sides. Halfway through
  // the sender stops once until the result channel has caught up completely.
  task automatic test_random_terms();
    int goal;
    int halfway;
    bit drained;
    goal = sent_bytes + RANDOM_BYTES - STEADY_BYTES;
    halfway = goal - (RANDOM_BYTES - STEADY_BYTES) / 2;
    drained = 1'b0;
    while (sent_bytes < goal) begin
      send_random_term();
      if (!drained && sent_bytes >= halfway) begin
        wait_for_drain();
        drained = 1'b1;
      end
    end
  endtask

  // The last stretch runs back to back with no idle cycles on either side.
  task automatic test_steady_stream();
    int goal;
    idle_on = 1'b0;
    goal = sent_bytes + STEADY_BYTES;
    while (sent_bytes < goal) send_random_term();
  endtask

  // The receiver stalls in random bursts while idling is enabled and is always
  // ready otherwise. Only one assignment reaches result_ready per edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && idle_on && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  // Every completed result transaction is compared with the oldest predicted
  // stem. Values are read just after the edge, before any update lands, so
  // they are the values the block saw at that edge.
  always @(posedge clk) begin
    lss_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_stems.size() == 0) begin
        $error("result transaction with no stem expected");
        mismatches++;
      end else begin
        want = pending_stems.pop_front();
        if (keep_length !== want.keep_length) begin
          $error("keep_length: expected %0d, actual %0d", want.keep_length, keep_length);
          mismatches++;
        end
        if (append_y !== want.append_y) begin
          $error("append_y: expected %0d, actual %0d", want.append_y, append_y);
          mismatches++;
        end
        if (too_long !== want.too_long) begin
          $error("too_long: expected %0d, actual %0d", want.too_long, too_long);
          mismatches++;
        end
        if (want.append_y) seen_y_stems++;
        if (want.too_long) seen_overlong++;
      end
    end
  end

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_terms();
    test_suffix_forms();
    test_overlong_terms();
    test_random_terms();
    test_steady_stream();
    char_valid <= 1'b0;
    // Each result follows its terminator through the input and result
    // registers; anything still missing after the wait below counts as lost.
    waited = 0;
    while (pending_stems.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_stems.size() != 0) begin
      $error("%0d predicted stems never arrived", pending_stems.size());
      mismatches += pending_stems.size();
    end
    repeat (8) @(posedge clk);
    $display("Sent %0d terms in %0d bytes, covering short, stemmed and overlong terms.",
             sent_terms, sent_bytes);
    $display("Results included %0d rewrites to -y and %0d overlong flags.",
             seen_y_stems, seen_overlong);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Safety net in case a handshake hangs.
  initial begin
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
